// ===== rtl/esmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the edge segment merge table.
// No dependencies; every other file of the block uses it.
package esmt_pkg;

    localparam int MAX_EDGES_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int SLOT_W        = 4;
    localparam int ST_W          = 3;
    localparam int POS_W         = 4;
    localparam int OCC_W         = 5;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    typedef logic [ST_W-1:0] t_status;

    localparam t_status ST_MERGED   = 3'd0;
    localparam t_status ST_INSERTED = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_DELETED  = 3'd3;
    localparam t_status ST_BADPOS   = 3'd4;

    typedef struct packed {
        logic                      vertical;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat, set up the walk
        logic walk;       // issue table reads
        logic merge_wr;   // extend the hit entry
        logic insert_wr;  // new entry at head
        logic full;       // no room, report it
        logic shift_wr;   // delete: move read entry one place forward
        logic del_done;   // delete finished
        logic del_bad;    // delete of an absent position
        logic push;       // result to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_del;     // opcode of the waiting input beat
        logic bad_pos;
        logic hit;
        logic walk_done;
        logic full;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/esmt_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the edge segment merge table: valid/ready and one segment command.
// Depends on esmt_pkg.
interface esmt_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic                                vertical;
    logic signed [esmt_pkg::COORD_W-1:0] start_x;
    logic signed [esmt_pkg::COORD_W-1:0] start_y;
    logic signed [esmt_pkg::COORD_W-1:0] end_x;
    logic signed [esmt_pkg::COORD_W-1:0] end_y;
    logic        [esmt_pkg::SLOT_W-1:0]  slot;

    modport source (
        output valid, opcode, vertical, start_x, start_y, end_x, end_y, slot,
        input  ready
    );
    modport sink (
        input  valid, opcode, vertical, start_x, start_y, end_x, end_y, slot,
        output ready
    );
endinterface

// ===== rtl/esmt_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the edge segment merge table: valid/ready, status, position, occupancy.
// Depends on esmt_pkg.
interface esmt_out_if;
    logic                         valid;
    logic                         ready;
    logic [esmt_pkg::ST_W-1:0]    status;
    logic [esmt_pkg::POS_W-1:0]   position;
    logic [esmt_pkg::OCC_W-1:0]   occupancy;

    modport source (
        output valid, status, position, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, position, occupancy,
        output ready
    );
endinterface

// ===== rtl/esmt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the edge segment merge table: input handshake and command issue.
// Depends on esmt_pkg.
module esmt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  esmt_pkg::t_stat i_stat,
    output esmt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DELETE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.in_del ? S_DELETE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.walk = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.merge_wr = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.walk_done) begin
                    if (i_stat.full) begin
                        o_cmd.full = 1'b1;
                    end else begin
                        o_cmd.insert_wr = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DELETE: begin
                if (i_stat.bad_pos) begin
                    o_cmd.del_bad = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.walk     = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                    if (i_stat.walk_done) begin
                        o_cmd.del_done = 1'b1;
                        n_state        = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/esmt_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the edge segment merge table: entry memory as a ring, walk
// pointers, merge compare, result and output registers. Depends on esmt_pkg.
module esmt_dp #(
    parameter int MAX_EDGES = esmt_pkg::MAX_EDGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_opcode,
    input  logic                                i_vertical,
    input  logic signed [esmt_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [esmt_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [esmt_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [esmt_pkg::COORD_W-1:0] i_end_y,
    input  logic        [esmt_pkg::SLOT_W-1:0]  i_slot,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic        [esmt_pkg::ST_W-1:0]    o_status,
    output logic        [esmt_pkg::POS_W-1:0]   o_position,
    output logic        [esmt_pkg::OCC_W-1:0]   o_occupancy,
    input  esmt_pkg::t_cmd                      i_cmd,
    output esmt_pkg::t_stat                     o_stat
);

    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int XW  = ((CW > esmt_pkg::SLOT_W) ? CW : esmt_pkg::SLOT_W) + 1;
    localparam int SW  = ((AW > esmt_pkg::SLOT_W) ? AW : esmt_pkg::SLOT_W) + 2;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_EDGES - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(MAX_EDGES);
    localparam logic [CW-1:0] DEPTH_C   = CW'(MAX_EDGES);

    // entry store, physical ring; logical position i sits at head + i
    esmt_pkg::t_entry r_mem [MAX_EDGES];

    esmt_pkg::t_entry              r_item;
    logic [esmt_pkg::SLOT_W-1:0]   r_slot;
    logic                          r_bad;
    logic [AW-1:0]                 r_head;
    logic [CW-1:0]                 r_count;
    logic [AW-1:0]                 r_rd_addr;
    logic [AW-1:0]                 r_rd_idx;
    logic [CW-1:0]                 r_rd_left;
    logic [AW-1:0]                 r_dst;
    esmt_pkg::t_entry              r_q;
    logic                          r_q_valid;
    logic [AW-1:0]                 r_q_addr;
    logic [AW-1:0]                 r_q_idx;
    esmt_pkg::t_status             r_res_st;
    logic [esmt_pkg::POS_W-1:0]    r_res_pos;
    logic                          r_out_valid;
    esmt_pkg::t_status             r_out_st;
    logic [esmt_pkg::POS_W-1:0]    r_out_pos;
    logic [esmt_pkg::OCC_W-1:0]    r_out_occ;

    logic                          rd_en;
    logic [AW-1:0]                 head_dec;
    logic [SW-1:0]                 del_sum;
    logic [SW-1:0]                 del_sum1;
    logic [AW-1:0]                 del_dst;
    logic [AW-1:0]                 del_src;
    logic                          in_bad;
    logic [XW-1:0]                 del_left;
    logic                          same_line;
    logic                          start_abut;
    logic                          end_abut;
    logic                          hit;
    esmt_pkg::t_entry              merged;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    esmt_pkg::t_entry              wr_data;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    assign head_dec = (r_head == '0) ? LAST_ADDR : r_head - AW'(1);

    // delete set-up: target and first source slot, wrapped once
    assign del_sum  = SW'(r_head) + SW'(i_slot);
    assign del_sum1 = del_sum + SW'(1);
    assign del_dst  = (del_sum  >= DEPTH_S) ? AW'(del_sum  - DEPTH_S) : AW'(del_sum);
    assign del_src  = (del_sum1 >= DEPTH_S) ? AW'(del_sum1 - DEPTH_S) : AW'(del_sum1);
    assign in_bad   = (XW'(i_slot) >= XW'(r_count));
    assign del_left = XW'(r_count) - XW'(i_slot) - XW'(1);

    // abut test on the registered read entry
    always_comb begin
        merged = r_q;
        if (r_item.vertical) begin
            same_line  = (r_q.start_x == r_item.start_x);
            start_abut = (r_q.start_y == r_item.end_y);
            end_abut   = (r_q.end_y   == r_item.start_y);
            if (start_abut) begin
                merged.start_y = r_item.start_y;
            end else begin
                merged.end_y = r_item.end_y;
            end
        end else begin
            same_line  = (r_q.start_y == r_item.start_y);
            start_abut = (r_q.start_x == r_item.end_x);
            end_abut   = (r_q.end_x   == r_item.start_x);
            if (start_abut) begin
                merged.start_x = r_item.start_x;
            end else begin
                merged.end_x = r_item.end_x;
            end
        end
    end

    assign hit = r_q_valid && (r_q.vertical == r_item.vertical) && same_line
                 && (start_abut || end_abut);

    assign rd_en = i_cmd.walk && (r_rd_left != '0);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_dst;
        wr_data = r_q;
        priority if (i_cmd.merge_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_q_addr;
            wr_data = merged;
        end else if (i_cmd.insert_wr) begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
            wr_data = r_item;
        end else if (i_cmd.shift_wr && r_q_valid) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[r_rd_addr];
        end
    end

    // walk pointers and captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item.vertical <= i_vertical;
            r_item.start_x  <= i_start_x;
            r_item.start_y  <= i_start_y;
            r_item.end_x    <= i_end_x;
            r_item.end_y    <= i_end_y;
            r_slot          <= i_slot;
            r_rd_idx        <= '0;
            if (i_opcode == esmt_pkg::OP_DEL) begin
                r_bad     <= in_bad;
                r_rd_addr <= del_src;
                r_dst     <= del_dst;
                r_rd_left <= in_bad ? '0 : CW'(del_left);
            end else begin
                r_bad     <= 1'b0;
                r_rd_addr <= r_head;
                r_rd_left <= r_count;
            end
        end else begin
            if (rd_en) begin
                r_rd_addr <= ring_inc(r_rd_addr);
                r_rd_idx  <= r_rd_idx + AW'(1);
                r_rd_left <= r_rd_left - CW'(1);
                r_q_addr  <= r_rd_addr;
                r_q_idx   <= r_rd_idx;
            end
            if (i_cmd.shift_wr && r_q_valid) begin
                r_dst <= ring_inc(r_dst);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
        end else begin
            r_q_valid <= rd_en;
            if (i_cmd.insert_wr) begin
                r_head  <= head_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_done) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.merge_wr) begin
            r_res_st  <= esmt_pkg::ST_MERGED;
            r_res_pos <= esmt_pkg::POS_W'(r_q_idx);
        end else if (i_cmd.insert_wr) begin
            r_res_st  <= esmt_pkg::ST_INSERTED;
            r_res_pos <= '0;
        end else if (i_cmd.full) begin
            r_res_st  <= esmt_pkg::ST_FULL;
            r_res_pos <= '0;
        end else if (i_cmd.del_done) begin
            r_res_st  <= esmt_pkg::ST_DELETED;
            r_res_pos <= r_slot;
        end else if (i_cmd.del_bad) begin
            r_res_st  <= esmt_pkg::ST_BADPOS;
            r_res_pos <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_st  <= r_res_st;
            r_out_pos <= r_res_pos;
            r_out_occ <= esmt_pkg::OCC_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_position  = r_out_pos;
    assign o_occupancy = r_out_occ;

    assign o_stat.in_del    = (i_opcode == esmt_pkg::OP_DEL);
    assign o_stat.bad_pos   = r_bad;
    assign o_stat.hit       = hit;
    assign o_stat.walk_done = (r_rd_left == '0) && !r_q_valid;
    assign o_stat.full      = (r_count == DEPTH_C);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/edge_segment_merge_table.sv =====
`timescale 1ns / 1ps
// Edge segment merge table: an ordered list of axis-aligned segments, newest first.
// An add beat extends the first abutting entry of the same orientation and line
// (start-abuts checked before end-abuts) or inserts the segment at the head; a
// delete beat removes the entry at a position and keeps the order.
// Channels: i_seg (command beats) and o_res (one result beat per command), both
// valid/ready; a beat moves at a clock edge with valid and ready high.
// Timing: a command is taken only while the block is idle. An add walks the
// held entries one per cycle through the registered read port of the entry
// memory and stops early on a hit; a delete moves one entry per cycle, from
// the entry after the slot to the oldest, and a bad position moves none. A
// command is accepted only once the result of the last one has gone to the
// output register, so the single read port sets the pace on a full table.
// Reset (i_rst_n low, synchronous) empties the table at once; entry contents are
// not cleared, only entries below the occupancy are ever read.
// Stall: the result sits in an output register; the next command is accepted
// while it waits, and that command's result is held back until o_res is taken.
// Depends on esmt_pkg, esmt_in_if, esmt_out_if, esmt_ctrl, esmt_dp.
module edge_segment_merge_table #(
    parameter int MAX_EDGES = esmt_pkg::MAX_EDGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esmt_in_if.sink    i_seg,
    esmt_out_if.source o_res
);

    esmt_pkg::t_cmd  cmd;
    esmt_pkg::t_stat stat;

    // state machine: handshake and sequencing
    esmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_seg.valid),
        .o_in_ready (i_seg.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // entry ring, compare, result registers
    esmt_dp #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opcode    (i_seg.opcode),
        .i_vertical  (i_seg.vertical),
        .i_start_x   (i_seg.start_x),
        .i_start_y   (i_seg.start_y),
        .i_end_x     (i_seg.end_x),
        .i_end_y     (i_seg.end_y),
        .i_slot      (i_seg.slot),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_status    (o_res.status),
        .o_position  (o_res.position),
        .o_occupancy (o_res.occupancy),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== rtl/esmt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the edge segment merge table, bound to the top level.
// Depends on esmt_pkg and edge_segment_merge_table.
module esmt_checker #(
    parameter int MAX_EDGES = esmt_pkg::MAX_EDGES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [esmt_pkg::ST_W-1:0]    i_status,
    input logic [esmt_pkg::POS_W-1:0]   i_position,
    input logic [esmt_pkg::OCC_W-1:0]   i_occupancy
);

    localparam logic [esmt_pkg::OCC_W-1:0] OCC_MAX = esmt_pkg::OCC_W'(MAX_EDGES);
    localparam logic                       WIDE    = (MAX_EDGES > 31);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_status) && $stable(i_position)
                                && $stable(i_occupancy))
        else $error("result payload changed while stalled");

    a_zero_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == esmt_pkg::ST_INSERTED || i_status == esmt_pkg::ST_FULL
                    || i_status == esmt_pkg::ST_BADPOS) |-> i_position == '0)
        else $error("nonzero position on insert, full or bad position");

    a_occ_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> WIDE || (i_occupancy <= OCC_MAX))
        else $error("occupancy above table depth");

    a_full_occ : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == esmt_pkg::ST_FULL |-> i_occupancy == OCC_MAX)
        else $error("table full reported below depth");

endmodule

bind edge_segment_merge_table esmt_checker #(
    .MAX_EDGES (MAX_EDGES)
) u_esmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_status    (o_res.status),
    .i_position  (o_res.position),
    .i_occupancy (o_res.occupancy)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of edge_segment_merge_table: directed and random segment commands.
// Depends on esmt_pkg, esmt_in_if, esmt_out_if and the RTL of the block.
module tb;
    import esmt_pkg::*;

    localparam int DEPTH       = MAX_EDGES_DEF;
    localparam int N_RANDOM    = 1750;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
    localparam int QUIET_LIMIT = 5000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES = 40;    // longer than the worst latency of one command
    localparam int MAX_REPORTS = 10;

    // One command beat as the generator and the predictor see it.
    typedef struct packed {
        logic                      opcode;
        logic                      vertical;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [SLOT_W-1:0]         slot;
    } t_seg_cmd;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [OCC_W-1:0]   occupancy;
    } t_seg_result;

    // Segment list, position 0 newest; only entries below count are meaningful.
    typedef struct packed {
        logic [OCC_W-1:0]      count;
        t_entry [DEPTH-1:0]    ents;
    } t_seg_table;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    esmt_in_if  seg_if ();
    esmt_out_if res_if ();

    edge_segment_merge_table #(.MAX_EDGES(DEPTH)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_seg   (seg_if),
        .o_res   (res_if)
    );

    always #5 clk = ~clk;

    t_seg_cmd    pending_cmds [$];       // commands not yet offered
    t_seg_result expected_results [$];   // predicted result beats, oldest first
    t_seg_table  plan_tbl;               // list state as the generator sees it
    t_seg_table  live_tbl;               // list state after the accepted beats

    int cmds_total    = 0;
    int cmds_offered  = 0;
    int cmds_accepted = 0;
    int results_seen  = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    int holds_done    = 0;
    int status_seen [5] = '{default: 0};

    // ------------------------------------------------------------------
    // Predictor: apply one command to a list, return the result beat.
    // Add: newest-to-oldest search for an entry of the same orientation on
    // the same line; start-abuts wins over end-abuts. No hit -> insert at
    // head, or table full. Delete: close the gap, or bad position.
    // ------------------------------------------------------------------
    function automatic t_seg_result apply_seg_cmd(inout t_seg_table tbl,
                                                  input t_seg_cmd c);
        t_seg_result r;
        bit          hit;
        int          n;
        n   = int'(tbl.count);
        hit = 1'b0;
        r.position = '0;
        if (c.opcode == OP_DEL) begin
            if (int'(c.slot) >= n) begin
                r.status = ST_BADPOS;
            end else begin
                for (int i = int'(c.slot); i + 1 < n; i++)
                    tbl.ents[i] = tbl.ents[i+1];
                tbl.count  = tbl.count - 1'b1;
                r.status   = ST_DELETED;
                r.position = c.slot;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!hit && tbl.ents[i].vertical == c.vertical) begin
                    if (!c.vertical && tbl.ents[i].start_y == c.start_y) begin
                        if (tbl.ents[i].start_x == c.end_x) begin
                            tbl.ents[i].start_x = c.start_x;
                            hit = 1'b1;
                        end else if (tbl.ents[i].end_x == c.start_x) begin
                            tbl.ents[i].end_x = c.end_x;
                            hit = 1'b1;
                        end
                    end else if (c.vertical && tbl.ents[i].start_x == c.start_x) begin
                        if (tbl.ents[i].start_y == c.end_y) begin
                            tbl.ents[i].start_y = c.start_y;
                            hit = 1'b1;
                        end else if (tbl.ents[i].end_y == c.start_y) begin
                            tbl.ents[i].end_y = c.end_y;
                            hit = 1'b1;
                        end
                    end
                    if (hit) r.position = POS_W'(i);
                end
            end
            if (hit) begin
                r.status = ST_MERGED;
            end else if (n >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int i = n; i > 0; i--)
                    tbl.ents[i] = tbl.ents[i-1];
                tbl.ents[0].vertical = c.vertical;
                tbl.ents[0].start_x  = c.start_x;
                tbl.ents[0].start_y  = c.start_y;
                tbl.ents[0].end_x    = c.end_x;
                tbl.ents[0].end_y    = c.end_y;
                tbl.count = tbl.count + 1'b1;
                r.status  = ST_INSERTED;
            end
        end
        r.occupancy = tbl.count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mix of extremes, a narrow band (so lines and ends collide) and full range.
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5, 6: return COORD_W'($urandom_range(8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_seg_cmd rand_cmd();
        t_seg_cmd c;
        c.opcode   = 1'($urandom_range(1));
        c.vertical = 1'($urandom_range(1));
        c.start_x  = pick_coord();
        c.start_y  = pick_coord();
        c.end_x    = pick_coord();
        c.end_y    = pick_coord();
        c.slot     = SLOT_W'($urandom_range(15));
        return c;
    endfunction

    // Add that abuts entry e at its start or at its end; free fields stay random.
    function automatic t_seg_cmd abut_cmd(t_entry e, bit at_start);
        t_seg_cmd c;
        c          = rand_cmd();
        c.opcode   = OP_ADD;
        c.vertical = e.vertical;
        if (!e.vertical) begin
            c.start_y = e.start_y;
            if (at_start) c.end_x = e.start_x;
            else          c.start_x = e.end_x;
        end else begin
            c.start_x = e.start_x;
            if (at_start) c.end_y = e.start_y;
            else          c.start_y = e.end_y;
        end
        return c;
    endfunction

    function automatic t_seg_cmd seg_cmd(logic op, logic vert, logic [31:0] sx,
                                         logic [31:0] sy, logic [31:0] ex,
                                         logic [31:0] ey, logic [3:0] slot);
        t_seg_cmd c;
        c.opcode = op; c.vertical = vert;
        c.start_x = sx; c.start_y = sy; c.end_x = ex; c.end_y = ey;
        c.slot = slot;
        return c;
    endfunction

    task automatic queue_cmd(input t_seg_cmd c);
        pending_cmds.push_back(c);
        void'(apply_seg_cmd(plan_tbl, c));
    endtask

    // Idle percentages: sender light / receiver heavy, then swapped, then none.
    function automatic int tx_idle_pct();
        if (cmds_accepted < cmds_total / 3)     return 31;
        if (cmds_accepted < 2 * cmds_total / 3) return 86;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (cmds_accepted < cmds_total / 3)     return 86;
        if (cmds_accepted < 2 * cmds_total / 3) return 31;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: new beat at the falling edge once the previous one is taken.
    // ------------------------------------------------------------------
    initial begin
        seg_if.valid    = 1'b0;
        seg_if.opcode   = OP_ADD;
        seg_if.vertical = 1'b0;
        seg_if.start_x  = '0;
        seg_if.start_y  = '0;
        seg_if.end_x    = '0;
        seg_if.end_y    = '0;
        seg_if.slot     = '0;
        res_if.ready    = 1'b0;
    end

    always @(negedge clk) begin
        t_seg_cmd c;
        if (!rst_n) begin
            seg_if.valid <= 1'b0;
        end else if (cmds_accepted == cmds_offered) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
                c = pending_cmds.pop_front();
                seg_if.opcode   <= c.opcode;
                seg_if.vertical <= c.vertical;
                seg_if.start_x  <= c.start_x;
                seg_if.start_y  <= c.start_y;
                seg_if.end_x    <= c.end_x;
                seg_if.end_y    <= c.end_y;
                seg_if.slot     <= c.slot;
                seg_if.valid    <= 1'b1;
                cmds_offered    <= cmds_offered + 1;
            end else begin
                seg_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, plus two long hold-offs in the no-idle phase
    // so the block parks a result and then stalls its input.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (rst_n && holds_done < 2 &&
                     cmds_accepted >= 2 * cmds_total / 3 + 50 + holds_done * 400) begin
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted command beat, check every result
    // beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_seg_cmd    c;
        t_seg_result got;
        t_seg_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.status    = res_if.status;
            got.position  = res_if.position;
            got.occupancy = res_if.occupancy;
            results_seen  <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: st=%0d pos=%0d occ=%0d",
                             $realtime, got.status, got.position, got.occupancy);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result %0d: exp st=%0d pos=%0d occ=%0d, got st=%0d pos=%0d occ=%0d",
                                 $realtime, results_seen, want.status, want.position,
                                 want.occupancy, got.status, got.position, got.occupancy);
                end
                if (want.status <= ST_BADPOS)
                    status_seen[want.status] <= status_seen[want.status] + 1;
            end
        end
        if (rst_n && seg_if.valid && seg_if.ready) begin
            c = seg_cmd(seg_if.opcode, seg_if.vertical, seg_if.start_x, seg_if.start_y,
                        seg_if.end_x, seg_if.end_y, seg_if.slot);
            expected_results.push_back(apply_seg_cmd(live_tbl, c));
            cmds_accepted <= cmds_accepted + 1;
        end
    end

    // Watchdog: too long without any beat on either channel.
    always @(posedge clk) begin
        if (!rst_n || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_seg_cmd c;
        int       k;
        plan_tbl = '0;
        live_tbl = '0;

        // Directed: empty-table deletes, horizontal and vertical merges at
        // both ends (start-abuts beats end-abuts), fill to full, add on a
        // full table with and without a hit, deletes at the edges, bad slot.
        queue_cmd(seg_cmd(OP_DEL, 1'b0, 0, 0, 0, 0, 4'd0));
        queue_cmd(seg_cmd(OP_DEL, 1'b1, 0, 0, 0, 0, 4'd15));
        queue_cmd(seg_cmd(OP_ADD, 1'b0, 10, 5, 20, 5, 4'd0));
        queue_cmd(seg_cmd(OP_ADD, 1'b0, 20, 5, 32'h7fff_ffff, 32'h8000_0000, 4'd3));
        queue_cmd(seg_cmd(OP_ADD, 1'b0, 32'h7fff_ffff, 5, 10, 5, 4'd9));
        queue_cmd(seg_cmd(OP_ADD, 1'b1, 32'hffff_ffff, 10, 32'hffff_ffff, 20, 4'd0));
        queue_cmd(seg_cmd(OP_ADD, 1'b1, 32'hffff_ffff, 20, 7, 32'h8000_0000, 4'd15));
        queue_cmd(seg_cmd(OP_ADD, 1'b1, 32'hffff_ffff, 32'hffff_fffb, 0, 10, 4'd6));
        queue_cmd(seg_cmd(OP_ADD, 1'b0, 0, 32'h8000_0000, 1, 32'h7fff_ffff, 4'd12));
        for (int j = 0; j < 13; j++)
            queue_cmd(seg_cmd(OP_ADD, 1'(j), 32'h8000_0000 + j, 1000 + j,
                              32'h7fff_ffff - j, 1000 + j, 4'(j)));
        queue_cmd(seg_cmd(OP_ADD, 1'b0, 0, 77, 0, 77, 4'd0));
        queue_cmd(abut_cmd(plan_tbl.ents[DEPTH-1], 1'b0));
        queue_cmd(seg_cmd(OP_DEL, 1'b0, 0, 0, 0, 0, 4'd15));
        queue_cmd(seg_cmd(OP_DEL, 1'b1, 0, 0, 0, 0, 4'd0));
        queue_cmd(seg_cmd(OP_DEL, 1'b0, 0, 0, 0, 0, 4'd14));

        // Random: mostly merges onto held entries, fresh adds and valid
        // deletes, the rest bad-slot deletes and unshaped noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            c = rand_cmd();
            k = $urandom_range(99);
            if (k < 40 && plan_tbl.count > 0) begin
                c = abut_cmd(plan_tbl.ents[$urandom_range(int'(plan_tbl.count) - 1)],
                             1'($urandom_range(1)));
            end else if (k < 65) begin
                c.opcode = OP_ADD;
            end else if (k < 85 && plan_tbl.count > 0) begin
                c.opcode = OP_DEL;
                c.slot   = SLOT_W'($urandom_range(int'(plan_tbl.count) - 1));
            end else if (k < 93 && plan_tbl.count < DEPTH) begin
                c.opcode = OP_DEL;
                c.slot   = SLOT_W'($urandom_range(15, int'(plan_tbl.count)));
            end
            queue_cmd(c);
        end
        cmds_total = pending_cmds.size();

        // Synchronous reset, released at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (cmds_accepted < cmds_total || expected_results.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d commands, %0d result beats checked, %0d mismatches",
                 cmds_total, results_seen, mismatch_count);
        $display("tb: merged %0d, inserted %0d, full %0d, deleted %0d, bad position %0d",
                 status_seen[ST_MERGED], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_DELETED], status_seen[ST_BADPOS]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== edge_segment_merge_table.f =====
rtl/esmt_pkg.sv
rtl/esmt_in_if.sv
rtl/esmt_out_if.sv
rtl/esmt_ctrl.sv
rtl/esmt_dp.sv
rtl/edge_segment_merge_table.sv
rtl/esmt_checker.sv
dv/tb.sv
